// ===== rtl/core/dac_pkg.sv =====
// ----------------------------------------------------------------------------
// dac_pkg
// Shared widths, register indexes and saturating fixed-point helpers for the
// dry air conductivity evaluator.
// ----------------------------------------------------------------------------
package dac_pkg;

    localparam int VW = 48;             // value width
    localparam int FB = 32;             // fraction bits
    localparam int HW = VW / 2;         // half width for partial products
    localparam int MW = 2 * VW - FB;    // product magnitude after the fraction shift
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_LIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_SQRT = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_OFS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_INV1 = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_INV2 = 3'd5;
    localparam logic [IDX_W-1:0] REG_COEF_INV3 = 3'd6;
    localparam logic [IDX_W-1:0] REG_COEF_INV4 = 3'd7;
    localparam int NUM_REGS = 8;

    localparam logic [VW-1:0] MAX_VAL = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MIN_VAL = {1'b1, {(VW-1){1'b0}}};
    localparam logic [MW-1:0] MAG_MAX = {{(MW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [MW-1:0] MAG_MIN = {{(MW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};

    typedef logic signed [VW-1:0] value_t;

    function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] a);
        mag_of = a[VW-1] ? (~a + {{(VW-1){1'b0}}, 1'b1}) : a;
    endfunction

    // signed result from sign and magnitude, saturated
    function automatic logic [VW-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic [VW-1:0] r;
        if (neg) begin
            if (m > MAG_MIN)
                r = MIN_VAL;
            else
                r = {VW{1'b0}} - m[VW-1:0];
        end
        else if (m > MAG_MAX)
            r = MAX_VAL;
        else
            r = m[VW-1:0];
        from_mag = r;
    endfunction

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1])
            sat_add = s[VW] ? MIN_VAL : MAX_VAL;
        else
            sat_add = s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1])
            sat_sub = s[VW] ? MIN_VAL : MAX_VAL;
        else
            sat_sub = s[VW-1:0];
    endfunction

endpackage

// ===== rtl/core/dac_delay.sv =====
// ----------------------------------------------------------------------------
// dac_delay
// Stallable delay line that keeps side values aligned with the pipeline.
// ----------------------------------------------------------------------------
module dac_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
                line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// ===== rtl/core/dac_fmul.sv =====
// ----------------------------------------------------------------------------
// dac_fmul
// Three-stage fixed-point multiplier: sign/magnitude, four half-width partial
// products, then sum, round half away from zero and saturate.
// ----------------------------------------------------------------------------
module dac_fmul
    import dac_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] a,
    input  logic [VW-1:0] b,
    output logic [VW-1:0] p
);

    localparam logic [2*VW-1:0] RND = {{(2*VW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    logic          neg1_reg, neg2_reg;
    logic [VW-1:0] ma_reg, mb_reg;
    logic [VW-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [VW-1:0] p_reg;
    logic [VW:0]   pp_mid;
    logic [2*VW-1:0] sum;

    always_comb
    begin
        pp_mid = {1'b0, pp_lh_reg} + {1'b0, pp_hl_reg};
        sum = {pp_hh_reg, {VW{1'b0}}}
            + {{(HW-1){1'b0}}, pp_mid, {HW{1'b0}}}
            + {{VW{1'b0}}, pp_ll_reg}
            + RND;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= a[VW-1] ^ b[VW-1];
            ma_reg    <= mag_of(a);
            mb_reg    <= mag_of(b);
            neg2_reg  <= neg1_reg;
            pp_ll_reg <= ma_reg[HW-1:0] * mb_reg[HW-1:0];
            pp_lh_reg <= ma_reg[HW-1:0] * mb_reg[VW-1:HW];
            pp_hl_reg <= ma_reg[VW-1:HW] * mb_reg[HW-1:0];
            pp_hh_reg <= ma_reg[VW-1:HW] * mb_reg[VW-1:HW];
            p_reg     <= from_mag(neg2_reg, sum[2*VW-1:FB]);
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/dac_recip.sv =====
// ----------------------------------------------------------------------------
// dac_recip
// Pipelined reciprocal: restoring long division of one by the reduced
// temperature, two quotient bits per stage, rounded half away from zero.
// ----------------------------------------------------------------------------
module dac_recip
    import dac_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] r,
    output logic [VW-1:0] ri,
    output logic          zero
);

    localparam int STAGES = VW / 2;
    // dividend is one at 2*FB fraction bits; quotient keeps VW bits
    localparam logic [VW-1:0] REM_INIT = {{(VW-(2*FB-VW)-1){1'b0}}, 1'b1, {(2*FB-VW){1'b0}}};
    // divisors at or below this give a quotient past the value range
    localparam logic [VW-1:0] SAT_LIM  = {REM_INIT[VW-2:0], 1'b0};

    logic [VW-1:0] rem_reg [STAGES+1];
    logic [VW-1:0] quo_reg [STAGES+1];
    logic [VW-1:0] div_reg [STAGES+1];
    logic          neg_reg [STAGES+1];
    logic          sat_reg [STAGES+1];
    logic          zero_reg [STAGES+1];
    logic [VW-1:0] rem_step [STAGES+1];
    logic [VW-1:0] quo_step [STAGES+1];
    logic [VW-1:0] ri_reg;
    logic          zero_out_reg;
    logic [VW-1:0] d_in;
    logic [VW:0]   rem_dbl;
    logic          round_up;
    logic [VW-1:0] quo_rnd;

    assign d_in = mag_of(r);

    always_comb
    begin
        logic [VW:0]   rr;
        logic [VW-1:0] qq;
        rem_step[0] = REM_INIT;
        quo_step[0] = {VW{1'b0}};
        for (int s = 1; s <= STAGES; s++)
        begin
            rr = {1'b0, rem_reg[s-1]};
            qq = quo_reg[s-1];
            for (int k = 0; k < 2; k++)
            begin
                rr = {rr[VW-1:0], 1'b0};
                if (rr >= {1'b0, div_reg[s-1]})
                begin
                    rr = rr - {1'b0, div_reg[s-1]};
                    qq = {qq[VW-2:0], 1'b1};
                end
                else
                    qq = {qq[VW-2:0], 1'b0};
            end
            rem_step[s] = rr[VW-1:0];
            quo_step[s] = qq;
        end
    end

    always_comb
    begin
        rem_dbl  = {rem_reg[STAGES], 1'b0};
        round_up = rem_dbl >= {1'b0, div_reg[STAGES]};
        quo_rnd  = quo_reg[STAGES] + {{(VW-1){1'b0}}, round_up};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_step[0];
            quo_reg[0]  <= quo_step[0];
            div_reg[0]  <= d_in;
            neg_reg[0]  <= r[VW-1];
            sat_reg[0]  <= d_in <= SAT_LIM;
            zero_reg[0] <= r == {VW{1'b0}};
            for (int s = 1; s <= STAGES; s++)
            begin
                rem_reg[s]  <= rem_step[s];
                quo_reg[s]  <= quo_step[s];
                div_reg[s]  <= div_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
            zero_out_reg <= zero_reg[STAGES];
            if (zero_reg[STAGES])
                ri_reg <= {VW{1'b0}};
            else if (sat_reg[STAGES])
                ri_reg <= neg_reg[STAGES] ? MIN_VAL : MAX_VAL;
            else
                ri_reg <= from_mag(neg_reg[STAGES], {{(MW-VW){1'b0}}, quo_rnd});
        end
    end

    assign ri   = ri_reg;
    assign zero = zero_out_reg;

endmodule

// ===== rtl/core/dac_sqrt.sv =====
// ----------------------------------------------------------------------------
// dac_sqrt
// Pipelined digit-by-digit floor square root, two root bits per stage.
// Non-positive inputs give zero.
// ----------------------------------------------------------------------------
module dac_sqrt
    import dac_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] r,
    output logic [VW-1:0] sq
);

    localparam int NW = VW + FB;    // radicand width
    localparam int RT = NW / 2;     // root width
    localparam int RW = RT + 2;     // remainder width
    localparam int SW = RT + 4;     // shifted remainder width
    localparam int STAGES = RT / 2;

    logic [NW-1:0] rad_reg  [STAGES];
    logic [RW-1:0] rem_reg  [STAGES];
    logic [RT-1:0] root_reg [STAGES];
    logic [NW-1:0] rad_step [STAGES];
    logic [RW-1:0] rem_step [STAGES];
    logic [RT-1:0] root_step [STAGES];

    always_comb
    begin
        logic [NW-1:0] nn;
        logic [RW-1:0] rm;
        logic [RT-1:0] rt;
        logic [SW-1:0] sh;
        logic [SW-1:0] trial;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                nn = (!r[VW-1] && r != {VW{1'b0}}) ? {r, {FB{1'b0}}} : {NW{1'b0}};
                rm = {RW{1'b0}};
                rt = {RT{1'b0}};
            end
            else
            begin
                nn = rad_reg[s-1];
                rm = rem_reg[s-1];
                rt = root_reg[s-1];
            end
            for (int k = 0; k < 2; k++)
            begin
                sh    = {rm, nn[NW-1:NW-2]};
                nn    = {nn[NW-3:0], 2'b00};
                trial = {2'b00, rt, 2'b01};
                if (sh >= trial)
                begin
                    sh = sh - trial;
                    rt = {rt[RT-2:0], 1'b1};
                end
                else
                    rt = {rt[RT-2:0], 1'b0};
                rm = sh[RW-1:0];
            end
            rad_step[s]  = nn;
            rem_step[s]  = rm;
            root_step[s] = rt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rad_reg[s]  <= rad_step[s];
                rem_reg[s]  <= rem_step[s];
                root_reg[s] <= root_step[s];
            end
        end
    end

    assign sq = {{(VW-RT){1'b0}}, root_reg[STAGES-1]};

endmodule

// ===== rtl/core/dry_air_conductivity_eval.sv =====
// Throughput: one word per cycle while the output is not stalled; the
// reciprocal (two quotient bits per stage) and square root (two root bits
// per stage) pipelines set the depth.
// A stalled output holds the whole pipeline; no word is lost or repeated.
// Reset clears the valid pipeline and all configuration registers to zero.
// ----------------------------------------------------------------------------
// dry_air_conductivity_eval
// Per-level dry air conductivity and, when requested, its temperature slope, saturated Q16.32.
// ----------------------------------------------------------------------------
module dry_air_conductivity_eval
    import dac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [VW-1:0]        cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [VW-1:0] temperature,
    input  logic signed [VW-1:0] inverse_temperature,
    input  logic                 want_slope,
    input  logic                 last_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [VW-1:0] conductivity,
    output logic signed [VW-1:0] conductivity_slope,
    output logic                 zero_temp_flag,
    output logic                 last_out
);

    localparam int LAT = 48;

    logic [VW-1:0]  cfg_reg [NUM_REGS];
    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;

    // config-derived constants
    logic [VW-1:0] c2h_reg, c5x2_reg, c6x3_reg, c7x4_reg, k1s;

    logic [VW-1:0] red, red_d, ri, ri_a, ri_b, ri_c, sq;
    logic          zero, zero_d, want_d;
    logic [VW-1:0] ti_a, ti_b;
    logic [VW-1:0] p_lin, p_sq, p_h, p_g;
    logic [VW-1:0] a1p_reg, a1_reg, a1_d, a3_reg, a3_d;
    logic [VW-1:0] m1, m2, m3, m4, s1_reg, s2_reg, a2_reg, cond_reg, cond_d;
    logic [VW-1:0] n1, n2, n3, n4, n5, u1_reg, u2_reg, a4_reg, slope_reg;

    function automatic logic [VW-1:0] times_small(input logic [VW-1:0] c,
                                                   input logic [2:0] k);
        logic [MW-1:0] m;
        m = {{(MW-VW){1'b0}}, mag_of(c)};
        times_small = from_mag(c[VW-1], m * {{(MW-3){1'b0}}, k});
    endfunction

    function automatic logic [VW-1:0] half_of(input logic [VW-1:0] c);
        logic [MW-1:0] m;
        m = {{(MW-VW){1'b0}}, mag_of(c)} + {{(MW-1){1'b0}}, 1'b1};
        half_of = from_mag(c[VW-1], {1'b0, m[MW-1:1]});
    endfunction

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (cfg_we)
                cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        c2h_reg  <= half_of(cfg_reg[REG_COEF_SQRT]);
        c5x2_reg <= times_small(cfg_reg[REG_COEF_INV2], 3'd2);
        c6x3_reg <= times_small(cfg_reg[REG_COEF_INV3], 3'd3);
        c7x4_reg <= times_small(cfg_reg[REG_COEF_INV4], 3'd4);
    end

    dac_fmul u_k1s (.clk(clk), .en(1'b1), .a(cfg_reg[REG_COEF_LIN]),
                    .b(cfg_reg[REG_SCALE]), .p(k1s));

    // reduced temperature
    dac_fmul u_red (.clk(clk), .en(en), .a(temperature), .b(cfg_reg[REG_SCALE]), .p(red));

    dac_recip u_recip (.clk(clk), .en(en), .r(red), .ri(ri), .zero(zero));
    dac_sqrt  u_sqrt  (.clk(clk), .en(en), .r(red), .sq(sq));

    dac_delay #(.WIDTH(VW), .DEPTH(20)) u_red_d (.clk(clk), .en(en), .d(red), .q(red_d));
    dac_delay #(.WIDTH(VW), .DEPTH(26)) u_ti_a (.clk(clk), .en(en),
                                                .d(inverse_temperature), .q(ti_a));
    dac_delay #(.WIDTH(VW), .DEPTH(18)) u_ti_b (.clk(clk), .en(en), .d(ti_a), .q(ti_b));
    dac_delay #(.WIDTH(VW), .DEPTH(4))  u_ri_a (.clk(clk), .en(en), .d(ri), .q(ri_a));
    dac_delay #(.WIDTH(VW), .DEPTH(4))  u_ri_b (.clk(clk), .en(en), .d(ri_a), .q(ri_b));
    dac_delay #(.WIDTH(VW), .DEPTH(4))  u_ri_c (.clk(clk), .en(en), .d(ri_b), .q(ri_c));
    dac_delay #(.WIDTH(1), .DEPTH(19))  u_zero_d (.clk(clk), .en(en), .d(zero), .q(zero_d));
    dac_delay #(.WIDTH(1), .DEPTH(47))  u_want_d (.clk(clk), .en(en), .d(want_slope),
                                                  .q(want_d));
    dac_delay #(.WIDTH(1), .DEPTH(LAT)) u_last_d (.clk(clk), .en(en), .d(last_in),
                                                  .q(last_out));

    // linear, root and offset terms
    dac_fmul u_lin (.clk(clk), .en(en), .a(cfg_reg[REG_COEF_LIN]), .b(red_d), .p(p_lin));
    dac_fmul u_sq  (.clk(clk), .en(en), .a(cfg_reg[REG_COEF_SQRT]), .b(sq), .p(p_sq));
    dac_fmul u_h   (.clk(clk), .en(en), .a(c2h_reg), .b(sq), .p(p_h));
    dac_fmul u_g   (.clk(clk), .en(en), .a(p_h), .b(ti_a), .p(p_g));
    dac_delay #(.WIDTH(VW), .DEPTH(16)) u_a1_d (.clk(clk), .en(en), .d(a1_reg), .q(a1_d));
    dac_delay #(.WIDTH(VW), .DEPTH(17)) u_a3_d (.clk(clk), .en(en), .d(a3_reg), .q(a3_d));

    // Horner chains in the inverse reduced temperature
    dac_fmul u_m1 (.clk(clk), .en(en), .a(cfg_reg[REG_COEF_INV4]), .b(ri), .p(m1));
    dac_fmul u_m2 (.clk(clk), .en(en), .a(s1_reg), .b(ri_a), .p(m2));
    dac_fmul u_m3 (.clk(clk), .en(en), .a(s2_reg), .b(ri_b), .p(m3));
    dac_fmul u_m4 (.clk(clk), .en(en), .a(a2_reg), .b(ri_c), .p(m4));
    dac_fmul u_n1 (.clk(clk), .en(en), .a(c7x4_reg), .b(ri), .p(n1));
    dac_fmul u_n2 (.clk(clk), .en(en), .a(u1_reg), .b(ri_a), .p(n2));
    dac_fmul u_n3 (.clk(clk), .en(en), .a(u2_reg), .b(ri_b), .p(n3));
    dac_fmul u_n4 (.clk(clk), .en(en), .a(a4_reg), .b(ri_c), .p(n4));
    dac_fmul u_n5 (.clk(clk), .en(en), .a(n4), .b(ti_b), .p(n5));
    dac_delay #(.WIDTH(VW), .DEPTH(3)) u_cond_d (.clk(clk), .en(en), .d(cond_reg), .q(cond_d));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1p_reg   <= sat_add(p_lin, p_sq);
            a1_reg    <= sat_add(a1p_reg, cfg_reg[REG_COEF_OFS]);
            a3_reg    <= sat_add(k1s, p_g);
            s1_reg    <= sat_add(cfg_reg[REG_COEF_INV3], m1);
            s2_reg    <= sat_add(cfg_reg[REG_COEF_INV2], m2);
            a2_reg    <= sat_add(cfg_reg[REG_COEF_INV1], m3);
            cond_reg  <= sat_add(a1_d, m4);
            u1_reg    <= sat_add(c6x3_reg, n1);
            u2_reg    <= sat_add(c5x2_reg, n2);
            a4_reg    <= sat_add(cfg_reg[REG_COEF_INV1], n3);
            slope_reg <= want_d ? sat_sub(a3_d, n5) : {VW{1'b0}};
        end
    end

    assign out_valid          = vld_reg[LAT-1];
    assign conductivity       = cond_d;
    assign conductivity_slope = slope_reg;
    assign zero_temp_flag     = zero_d;

endmodule

// ===== rtl/core/dac_checker.sv =====
// ----------------------------------------------------------------------------
// dac_checker
// Port-level checks for the conductivity evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module dac_checker
    import dac_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [VW-1:0] conductivity,
    input logic signed [VW-1:0] conductivity_slope,
    input logic                 zero_temp_flag,
    input logic                 last_out
);

    // held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(conductivity)
            && $stable(conductivity_slope) && $stable(zero_temp_flag) && $stable(last_out))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result word valid during reset");

endmodule

bind dry_air_conductivity_eval dac_checker u_dac_checker (.*);
